// ----- rtl/sxl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sxl_pkg
// Shared types and constants for the s-expression token lexer: byte codes,
// token tags, lexer modes and the token transaction that travels between the
// front and back halves.
// ----------------------------------------------------------------------------
package sxl_pkg;

   localparam int START_W = 12;
   localparam int LEN_W   = 13;
   localparam int IDX_W   = 6;

   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;

   typedef enum logic [2:0] {
      TAG_LPAREN = 3'd0,
      TAG_RPAREN = 3'd1,
      TAG_ADD    = 3'd2,
      TAG_SUB    = 3'd3,
      TAG_MUL    = 3'd4,
      TAG_DIV    = 3'd5,
      TAG_SYM    = 3'd6,
      TAG_NUM    = 3'd7
   } tag_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_SYM  = 2'd1,
      MODE_NUM  = 2'd2
   } mode_type;

   typedef struct packed {
      tag_type            tag;
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   len;
   } tok_type;

   // One queue entry holds every token raised by one input byte.
   typedef struct packed {
      logic [1:0] ntok;
      logic       eos;
      tok_type    tok0;
      tok_type    tok1;
   } entry_type;

endpackage
`default_nettype wire

// ----- rtl/sxl_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sxl_front
// Byte classifier and run tracker. Takes one byte per cycle unless the queue is
// full, closes and opens symbol and number runs and pushes that byte's tokens.
// ----------------------------------------------------------------------------
module sxl_front
   import sxl_pkg::*;
#(
   parameter int MAX_STRING_LEN = 4096
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] char_byte
   input  wire logic       req_tlast,   // end_of_string
   input  wire logic       q_full,
   output logic            q_push,
   output entry_type       q_entry
);

   localparam int POS_W = (MAX_STRING_LEN > 2) ? $clog2(MAX_STRING_LEN) : 1;
   localparam int RUN_W = $clog2(MAX_STRING_LEN + 1);

   mode_type           mode_ff, mode_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   rstart_ff, rstart_in;
   logic [RUN_W-1:0]   rlen_ff, rlen_in;

   logic               fire;
   logic               is_digit, is_upper, run_cont;
   logic               close_vld, op_vld, flush_vld;
   tag_type            op_tag;
   mode_type           mode2;
   logic [POS_W-1:0]   start2, pos_inc;
   logic [RUN_W-1:0]   len2, len_inc;
   tok_type            tok_a, tok_b, tok_c;

   assign req_tready = !q_full;
   assign fire       = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pos_ff    <= '0;
         rstart_ff <= '0;
         rlen_ff   <= '0;
      end else begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         rstart_ff <= rstart_in;
         rlen_ff   <= rlen_in;
      end
   end

   always_comb begin
      is_digit = (req_tdata >= CH_DIGIT_0) && (req_tdata <= CH_DIGIT_9);
      is_upper = (req_tdata >= CH_UPPER_A) && (req_tdata <= CH_UPPER_Z);
      run_cont = ((mode_ff == MODE_SYM) && is_upper) || ((mode_ff == MODE_NUM) && is_digit);
      pos_inc  = (pos_ff == POS_W'(MAX_STRING_LEN - 1)) ? pos_ff : pos_ff + 1'b1;
      len_inc  = (rlen_ff == RUN_W'(MAX_STRING_LEN)) ? rlen_ff : rlen_ff + 1'b1;

      // close the open run when this byte falls outside its class
      close_vld = (mode_ff != MODE_IDLE) && !run_cont;
      mode2     = run_cont ? mode_ff : MODE_IDLE;
      start2    = rstart_ff;
      len2      = run_cont ? len_inc : rlen_ff;
      op_vld    = 1'b0;
      op_tag    = TAG_LPAREN;

      if (!run_cont) begin
         case (req_tdata)
            CH_LPAREN: begin
               op_vld = 1'b1;
               op_tag = TAG_LPAREN;
            end
            CH_RPAREN: begin
               op_vld = 1'b1;
               op_tag = TAG_RPAREN;
            end
            CH_PLUS: begin
               op_vld = 1'b1;
               op_tag = TAG_ADD;
            end
            CH_MINUS: begin
               op_vld = 1'b1;
               op_tag = TAG_SUB;
            end
            CH_STAR: begin
               op_vld = 1'b1;
               op_tag = TAG_MUL;
            end
            CH_SLASH: begin
               op_vld = 1'b1;
               op_tag = TAG_DIV;
            end
            CH_QUOTE: begin
               mode2  = MODE_SYM;
               start2 = pos_inc;
               len2   = '0;
            end
            default: begin
               if (is_digit) begin
                  mode2  = MODE_NUM;
                  start2 = pos_ff;
                  len2   = RUN_W'(1);
               end
            end
         endcase
      end

      // flush whatever run is still open on the last byte
      flush_vld = req_tlast && (mode2 != MODE_IDLE);

      tok_a.tag   = (mode_ff == MODE_SYM) ? TAG_SYM : TAG_NUM;
      tok_a.start = START_W'(rstart_ff);
      tok_a.len   = LEN_W'(rlen_ff);
      tok_b.tag   = op_tag;
      tok_b.start = START_W'(pos_ff);
      tok_b.len   = LEN_W'(1);
      tok_c.tag   = (mode2 == MODE_SYM) ? TAG_SYM : TAG_NUM;
      tok_c.start = START_W'(start2);
      tok_c.len   = LEN_W'(len2);

      q_entry.ntok = 2'(close_vld) + 2'(op_vld) + 2'(flush_vld);
      q_entry.eos  = req_tlast;
      q_entry.tok0 = close_vld ? tok_a : (op_vld ? tok_b : tok_c);
      q_entry.tok1 = op_vld ? tok_b : tok_c;
      q_push       = fire && ((q_entry.ntok != 2'd0) || req_tlast);

      mode_in   = mode_ff;
      pos_in    = pos_ff;
      rstart_in = rstart_ff;
      rlen_in   = rlen_ff;
      if (fire) begin
         if (req_tlast) begin
            mode_in   = MODE_IDLE;
            pos_in    = '0;
            rstart_in = '0;
            rlen_in   = '0;
         end else begin
            mode_in   = mode2;
            pos_in    = pos_inc;
            rstart_in = start2;
            rlen_in   = len2;
         end
      end
   end

   property p_pos_restart;
      @(posedge clock) disable iff (reset) (fire && req_tlast) |=> (pos_ff == '0);
   endproperty
   a_pos_restart: assert property (p_pos_restart) else $error("position not cleared");

   property p_len_bound;
      @(posedge clock) disable iff (reset) rlen_ff <= RUN_W'(MAX_STRING_LEN);
   endproperty
   a_len_bound: assert property (p_len_bound) else $error("run length out of range");

endmodule
`default_nettype wire

// ----- rtl/sxl_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sxl_queue
// Short first-in first-out queue of per-byte token entries between the
// front and back halves.
// ----------------------------------------------------------------------------
module sxl_queue
   import sxl_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type wdata,
   input  wire logic      pop,
   output entry_type      rdata,
   output logic           full,
   output logic           empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == CNT_W'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   property p_no_overrun;
      @(posedge clock) disable iff (reset) push |-> !full;
   endproperty
   a_no_overrun: assert property (p_no_overrun) else $error("queue overrun");

   property p_no_underrun;
      @(posedge clock) disable iff (reset) pop |-> !empty;
   endproperty
   a_no_underrun: assert property (p_no_underrun) else $error("queue underrun");

endmodule
`default_nettype wire

// ----- rtl/sxl_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sxl_back
// Token issuer. Drains queue entries one token per cycle unless stalled, numbers
// tokens against the list capacity and holds each result in the output register.
// ----------------------------------------------------------------------------
module sxl_back
   import sxl_pkg::*;
#(
   parameter int MAX_TOKENS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire entry_type   q_head,
   input  wire logic        q_empty,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,  // [11:0] start_offset, [24:12] token_length,
                                        // [30:25] token_index
   output logic [3:0]       rsp_tuser,  // [2:0] token_tag, [3] overflow
   output logic             rsp_tlast   // last_of_run
);

   localparam int CNT_W = $clog2(MAX_TOKENS + 1);

   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               sel_ff, sel_in;
   logic               valid_ff, valid_in;
   tok_type            tok_ff, tok_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               ovf_ff, ovf_in;
   logic               last_ff, last_in;
   logic               load;

   assign load = !valid_ff || rsp_tready;

   always_comb begin
      q_pop    = 1'b0;
      cnt_in   = cnt_ff;
      sel_in   = sel_ff;
      valid_in = valid_ff;
      tok_in   = tok_ff;
      idx_in   = idx_ff;
      ovf_in   = ovf_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b0;
         if (!q_empty) begin
            if (q_head.ntok == 2'd0) begin
               // end of string with no token: just restart the count
               q_pop  = 1'b1;
               cnt_in = '0;
            end else begin
               valid_in = 1'b1;
               tok_in   = sel_ff ? q_head.tok1 : q_head.tok0;
               last_in  = sel_ff || (q_head.ntok == 2'd1);
               if (cnt_ff < CNT_W'(MAX_TOKENS)) begin
                  idx_in = IDX_W'(cnt_ff);
                  ovf_in = 1'b0;
                  cnt_in = cnt_ff + 1'b1;
               end else begin
                  idx_in = '0;
                  ovf_in = 1'b1;
               end
               if (last_in) begin
                  q_pop  = 1'b1;
                  sel_in = 1'b0;
                  if (q_head.eos) begin
                     cnt_in = '0;
                  end
               end else begin
                  sel_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         sel_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff  <= tok_in;
      idx_ff  <= idx_in;
      ovf_ff  <= ovf_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, idx_ff, tok_ff.len, tok_ff.start};
   assign rsp_tuser  = {ovf_ff, tok_ff.tag};
   assign rsp_tlast  = last_ff;

   property p_cnt_bound;
      @(posedge clock) disable iff (reset) cnt_ff <= CNT_W'(MAX_TOKENS);
   endproperty
   a_cnt_bound: assert property (p_cnt_bound) else $error("token count out of range");

   property p_ovf_index;
      @(posedge clock) disable iff (reset) (valid_ff && ovf_ff) |-> (idx_ff == '0);
   endproperty
   a_ovf_index: assert property (p_ovf_index) else $error("dropped token carries an index");

endmodule
`default_nettype wire

// ----- rtl/sexpr_token_lexer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sexpr_token_lexer
// Byte-serial lexer for a small s-expression language.
// ----------------------------------------------------------------------------
// The block takes one byte of a command string per cycle on the req_ channel
// (tlast marks the last byte) and returns tokens on the rsp_ channel as tag,
// start offset, length, list index and an overflow flag; rsp_tlast marks the
// last token raised by a byte. A byte raises zero, one or two tokens. The
// front half classifies each byte combinationally and writes its tokens to
// a four-entry queue; the back half issues one token per cycle into the
// output register, so input runs at one byte per cycle as long as the output
// keeps up, and the two tokens of a byte leave one after the other. An
// accepted byte's first token passes through the queue and then the output
// register. Token numbering and byte offsets restart after every string;
// tokens past MAX_TOKENS are still reported, flagged as overflow.
// ----------------------------------------------------------------------------
module sexpr_token_lexer
   import sxl_pkg::*;
#(
   parameter int MAX_TOKENS     = 64,
   parameter int MAX_STRING_LEN = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_byte
   input  wire logic        req_tlast,   // end_of_string
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [11:0] start_offset, [24:12] token_length,
                                         // [30:25] token_index
   output logic [3:0]       rsp_tuser,   // [2:0] token_tag, [3] overflow
   output logic             rsp_tlast    // last_of_run
);

   localparam int QUEUE_DEPTH = 4;

   logic       q_full, q_empty, q_push, q_pop;
   entry_type  q_wdata, q_head;

   sxl_front #(
      .MAX_STRING_LEN (MAX_STRING_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_wdata)
   );

   sxl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_head),
      .full  (q_full),
      .empty (q_empty)
   );

   sxl_back #(
      .MAX_TOKENS (MAX_TOKENS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_head     (q_head),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// ----- test/sxl_token_checker.sv -----
// ----------------------------------------------------------------------------
// sxl_token_checker
// Watches both streams of the s-expression token lexer. Every accepted byte is
// lexed by a local model of the block, and the tokens it raises are queued in
// order. Every accepted token is compared field by field with the oldest
// queued one. Tokens left queued when the end check is raised are failures.
// ----------------------------------------------------------------------------
module sxl_token_checker
   import sxl_pkg::*;
#(
   parameter int MAX_TOKENS     = 64,
   parameter int MAX_STRING_LEN = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,
   input  wire logic [3:0]  rsp_tuser,
   input  wire logic        rsp_tlast,
   input  wire logic        end_check,
   output int               tokens_due_count,
   output int               mismatch_count
);

   localparam logic [START_W-1:0] POS_CEIL = START_W'(MAX_STRING_LEN - 1);
   localparam logic [LEN_W-1:0]   LEN_CEIL = LEN_W'(MAX_STRING_LEN);

   typedef struct packed {
      tag_type            tag;
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   len;
      logic [IDX_W-1:0]   index;
      logic               ovf;
      logic               last;
   } lex_token_t;

   lex_token_t         tokens_due[$];
   lex_token_t         step_tokens[2];
   int                 step_count;
   mode_type           mode;
   logic [START_W-1:0] run_start;
   logic [LEN_W-1:0]   run_len;
   logic [START_W-1:0] byte_pos;
   int                 listed_tokens;
   int                 failures = 0;
   int                 tokens_seen = 0;

   function automatic logic [START_W-1:0] next_pos(input logic [START_W-1:0] p);
      return (p >= POS_CEIL) ? POS_CEIL : p + 1'b1;
   endfunction

   task automatic restart_string();
      mode          = MODE_IDLE;
      run_start     = '0;
      run_len       = '0;
      byte_pos      = '0;
      listed_tokens = 0;
   endtask

   task automatic report_mismatch(input string what);
      failures++;
      if (failures <= 60)
         $display("%0t: token %0d: %s", $time, tokens_seen, what);
   endtask

   // A full list still reports the token, flagged and with index zero.
   task automatic raise_token(input tag_type tag, input logic [START_W-1:0] start,
                              input logic [LEN_W-1:0] len);
      lex_token_t t;
      t.tag   = tag;
      t.start = start;
      t.len   = len;
      t.last  = 1'b0;
      if (listed_tokens < MAX_TOKENS) begin
         t.index = IDX_W'(listed_tokens);
         t.ovf   = 1'b0;
         listed_tokens++;
      end else begin
         t.index = '0;
         t.ovf   = 1'b1;
      end
      step_tokens[step_count] = t;
      step_count++;
   endtask

   task automatic lex_byte(input logic [7:0] c, input logic eos);
      logic               consumed;
      logic [START_W-1:0] pos;
      consumed   = 1'b0;
      pos        = byte_pos;
      step_count = 0;

      // Close an open run on the first byte outside its class.
      case (mode)
         MODE_SYM: begin
            if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
               if (run_len < LEN_CEIL) run_len++;
               consumed = 1'b1;
            end else begin
               raise_token(TAG_SYM, run_start, run_len);
               mode = MODE_IDLE;
            end
         end
         MODE_NUM: begin
            if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
               if (run_len < LEN_CEIL) run_len++;
               consumed = 1'b1;
            end else begin
               raise_token(TAG_NUM, run_start, run_len);
               mode = MODE_IDLE;
            end
         end
         default: mode = MODE_IDLE;
      endcase

      if (!consumed) begin
         case (c)
            CH_LPAREN: raise_token(TAG_LPAREN, pos, LEN_W'(1));
            CH_RPAREN: raise_token(TAG_RPAREN, pos, LEN_W'(1));
            CH_PLUS:   raise_token(TAG_ADD, pos, LEN_W'(1));
            CH_MINUS:  raise_token(TAG_SUB, pos, LEN_W'(1));
            CH_STAR:   raise_token(TAG_MUL, pos, LEN_W'(1));
            CH_SLASH:  raise_token(TAG_DIV, pos, LEN_W'(1));
            CH_QUOTE: begin
               mode      = MODE_SYM;
               run_start = next_pos(pos);
               run_len   = '0;
            end
            default: begin
               if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
                  mode      = MODE_NUM;
                  run_start = pos;
                  run_len   = LEN_W'(1);
               end
            end
         endcase
      end

      // Flush a run still open on the last byte, then start the next string.
      if (eos) begin
         if (mode == MODE_SYM)
            raise_token(TAG_SYM, run_start, run_len);
         else if (mode == MODE_NUM)
            raise_token(TAG_NUM, run_start, run_len);
         restart_string();
      end else begin
         byte_pos = next_pos(pos);
      end

      if (step_count > 0) step_tokens[step_count-1].last = 1'b1;
      for (int i = 0; i < step_count; i++) tokens_due.push_back(step_tokens[i]);
   endtask

   always @(posedge clock) begin : watch
      lex_token_t due;
      if (reset) begin
         restart_string();
         tokens_due.delete();
      end else begin
         if (req_tvalid && req_tready) lex_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (tokens_due.size() == 0) begin
               report_mismatch($sformatf("unexpected token, tag %0d start %0d len %0d",
                                         rsp_tuser[2:0], rsp_tdata[11:0], rsp_tdata[24:12]));
            end else begin
               due = tokens_due.pop_front();
               if (rsp_tuser[2:0] !== due.tag)
                  report_mismatch($sformatf("tag %0d, due %0d", rsp_tuser[2:0], due.tag));
               if (rsp_tdata[11:0] !== due.start)
                  report_mismatch($sformatf("start %0d, due %0d", rsp_tdata[11:0], due.start));
               if (rsp_tdata[24:12] !== due.len)
                  report_mismatch($sformatf("length %0d, due %0d", rsp_tdata[24:12], due.len));
               if (rsp_tdata[30:25] !== due.index)
                  report_mismatch($sformatf("index %0d, due %0d", rsp_tdata[30:25], due.index));
               if (rsp_tuser[3] !== due.ovf)
                  report_mismatch($sformatf("overflow %0b, due %0b", rsp_tuser[3], due.ovf));
               if (rsp_tlast !== due.last)
                  report_mismatch($sformatf("tlast %0b, due %0b", rsp_tlast, due.last));
            end
            tokens_seen++;
         end
         if (end_check) begin
            while (tokens_due.size() > 0) begin
               due = tokens_due.pop_front();
               report_mismatch($sformatf("never arrived, tag %0d start %0d len %0d",
                                         due.tag, due.start, due.len));
            end
         end
      end
      tokens_due_count <= tokens_due.size();
      mismatch_count   <= failures;
   end

endmodule

// ----- test/sexpr_token_lexer_test.sv -----
// ----------------------------------------------------------------------------
// sexpr_token_lexer_test
// Feeds command strings to the s-expression token lexer: a short directed
// set, a full token list, an overlong string and then random phrases with
// noise. The sender works in bursts and the receiver stalls at varying rates;
// the checker beside the block predicts every token and counts mismatches.
// ----------------------------------------------------------------------------
module sexpr_token_lexer_test;
   import sxl_pkg::*;

   localparam int MAX_TOKENS     = 64;
   localparam int MAX_STRING_LEN = 4096;
   localparam int TEXT_ITEMS     = 1300;
   localparam int RUN_LIMIT      = 1_000_000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tlast  = 1'b0;
   logic        rsp_tready = 1'b0;
   logic        end_check  = 1'b0;
   wire logic   req_tready;
   wire logic   rsp_tvalid;
   wire logic [31:0] rsp_tdata;
   wire logic [3:0]  rsp_tuser;
   wire logic   rsp_tlast;
   int          tokens_due_count;
   int          mismatch_count;

   int          burst_left       = 0;
   int          stall_pct        = 0;
   int          stall_phase_left = 0;
   int          cycle_count      = 0;
   int          text_items       = 0;
   logic [7:0]  phrase[$];

   sexpr_token_lexer #(
      .MAX_TOKENS     (MAX_TOKENS),
      .MAX_STRING_LEN (MAX_STRING_LEN)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   sxl_token_checker #(
      .MAX_TOKENS     (MAX_TOKENS),
      .MAX_STRING_LEN (MAX_STRING_LEN)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tlast        (req_tlast),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tuser        (rsp_tuser),
      .rsp_tlast        (rsp_tlast),
      .end_check        (end_check),
      .tokens_due_count (tokens_due_count),
      .mismatch_count   (mismatch_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver: stall rate changes from phase to phase, including none at all.
   always @(posedge clock) begin
      if (stall_phase_left == 0) begin
         case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 30;
            2:       stall_pct = 60;
            default: stall_pct = 85;
         endcase
         stall_phase_left = $urandom_range(16, 160);
      end
      stall_phase_left--;
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [7:0] op_char(input int k);
      case (k)
         0:       return CH_LPAREN;
         1:       return CH_RPAREN;
         2:       return CH_PLUS;
         3:       return CH_MINUS;
         4:       return CH_STAR;
         default: return CH_SLASH;
      endcase
   endfunction

   // Hold the byte until the transaction completes; open a gap between bursts.
   task automatic send_byte(input logic [7:0] c, input logic eos);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= eos;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   task automatic add_piece(input int kind);
      int n;
      case (kind)
         0, 1, 2: begin
            phrase.push_back(op_char($urandom_range(0, 5)));
            text_items++;
         end
         3, 4: begin
            n = $urandom_range(1, 5);
            repeat (n) phrase.push_back(CH_DIGIT_0 + 8'($urandom_range(0, 9)));
            text_items += n;
         end
         5, 6: begin
            n = $urandom_range(0, 5);
            phrase.push_back(CH_QUOTE);
            repeat (n) phrase.push_back(CH_UPPER_A + 8'($urandom_range(0, 25)));
            text_items += n + 1;
         end
         7:       phrase.push_back(8'h20);
         default: phrase.push_back(8'($urandom_range(0, 255)));
      endcase
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: every operator, runs closed by the next byte, flush at the
      // end, a quote on the last byte, and the byte extremes.
      send_string("(+-*/)");
      send_string("'AZ9'");
      send_string("12(");
      send_string("'");
      send_string("7");
      send_string("'Q-");
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b1);

      // Full token list, with a number flushed after it.
      repeat (70) send_byte(CH_PLUS, 1'b0);
      send_byte(CH_DIGIT_0 + 8'd5, 1'b1);

      // Overlong string: position, symbol start and run length all saturate.
      send_byte(CH_DIGIT_0 + 8'd1, 1'b0);
      repeat (MAX_STRING_LEN + 24) send_byte(CH_DIGIT_9, 1'b0);
      send_byte(CH_PLUS, 1'b0);
      send_byte(CH_QUOTE, 1'b0);
      send_byte(CH_UPPER_A, 1'b0);
      send_byte(CH_UPPER_Z, 1'b0);
      send_byte(CH_LPAREN, 1'b1);

      // Random phrases; now and then one long enough to fill the list.
      while (text_items < TEXT_ITEMS) begin
         phrase.delete();
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(64, 100)) add_piece($urandom_range(0, 6));
         else
            repeat ($urandom_range(1, 12)) add_piece($urandom_range(0, 9));
         for (int i = 0; i < phrase.size(); i++)
            send_byte(phrase[i], i == phrase.size() - 1);
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (tokens_due_count != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      end_check <= 1'b1;
      repeat (2) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
